// ===== rtl/core/irl_pkg.sv =====
// ----------------------------------------------------------------------------
// irl_pkg
// Shared types, constants and helper functions for the indexed record list.
// ----------------------------------------------------------------------------
package irl_pkg;

  localparam int CAPACITY   = 16;
  localparam int NAME_BYTES = 20;
  localparam int NAME_SLOTS = 24;
  localparam int NAME_W     = NAME_SLOTS * 8;
  localparam int WORD_W     = 64;
  localparam int SCORE_W    = 16;
  localparam int MARK_W     = 8;
  localparam int POS_W      = 6;
  localparam int TOTAL_W    = 7;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W      = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_MAX    = 2'd2,
    MODE_FIND   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SHIFT_UP,
    ST_SHIFT_DOWN,
    ST_FLUSH,
    ST_INS_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_SCAN_END
  } state_t;

  typedef enum logic [1:0] {
    SCAN_ZERO,
    SCAN_TOP,
    SCAN_NEXT
  } scan_sel_t;

  typedef enum logic [2:0] {
    EMIT_PLAIN,
    EMIT_INSERTED,
    EMIT_DELETED,
    EMIT_MAX,
    EMIT_MORE,
    EMIT_LAST
  } emit_kind_t;

  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [SCORE_W-1:0] score;
  } record_t;

  typedef struct packed {
    logic       load;
    logic       scan_load;
    scan_sel_t  scan_sel;
    logic       shift_up;
    logic       shift_down;
    logic       scan_read;
    logic       write_new;
    logic       count_inc;
    logic       count_dec;
    logic       emit;
    emit_kind_t emit_kind;
    status_t    emit_status;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  pos_gt;
    logic  pos_eq;
    logic  last_pos;
    logic  full;
    logic  count_zero;
    logic  scan_at_pos;
    logic  scan_at_top;
    logic  hit;
    logic  pend_valid;
  } dp_stat_t;

  // Cuts the name to NAME_BYTES bytes and clears every byte after the first
  // zero byte, so that equal strings give equal words.
  function automatic logic [NAME_W-1:0] normalize_name(input logic [NAME_W-1:0] raw);
    logic              ended;
    logic [7:0]        b;
    logic [NAME_W-1:0] res;
    ended = 1'b0;
    res   = '0;
    for (int i = 0; i < NAME_SLOTS; i++) begin
      b = raw[i*8 +: 8];
      if ((i >= NAME_BYTES) || ended) begin
        b = 8'h00;
      end
      if (b == 8'h00) begin
        ended = 1'b1;
      end
      res[i*8 +: 8] = b;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/irl_datapath.sv =====
// ----------------------------------------------------------------------------
// irl_datapath
// Record memory, record count, scan pointer, match and maximum tracking, and
// the result register.
// ----------------------------------------------------------------------------
module irl_datapath
  import irl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [1:0]          mode,
  input  logic [POS_W-1:0]    position,
  input  logic [WORD_W-1:0]   name_word0,
  input  logic [WORD_W-1:0]   name_word1,
  input  logic [WORD_W-1:0]   name_word2,
  input  logic [SCORE_W-1:0]  score_in,
  output logic                done,
  output logic [1:0]          status,
  output logic [TOTAL_W-1:0]  entry_total,
  output logic [MARK_W-1:0]   max_mark,
  output logic                found,
  output logic [POS_W-1:0]    match_position,
  output logic [SCORE_W-1:0]  match_score,
  output logic                last
);

  record_t            mem [CAPACITY];
  record_t            rd_data;

  mode_t              mode_q;
  logic [POS_W-1:0]   pos_q;
  logic [NAME_W-1:0]  key;
  logic [SCORE_W-1:0] score_q;

  logic [COUNT_W-1:0] count;
  logic [IDX_W-1:0]   scan;
  logic               mv_valid;
  logic [IDX_W-1:0]   mv_dst;
  logic               chk_valid;
  logic [IDX_W-1:0]   chk_idx;
  logic               pend_valid;
  logic [IDX_W-1:0]   pend_idx;
  logic [SCORE_W-1:0] pend_score;
  logic [SCORE_W-1:0] best;

  logic [CMP_W-1:0]   pos_x;
  logic [CMP_W-1:0]   cnt_x;
  logic               hit;
  logic               rd_en;

  assign pos_x = CMP_W'(pos_q);
  assign cnt_x = CMP_W'(count);
  assign hit   = chk_valid && (mode_q == MODE_FIND) && (rd_data.name == key);
  assign rd_en = cmd.shift_up || cmd.shift_down || cmd.scan_read;

  always_comb begin
    stat.mode        = mode_q;
    stat.pos_gt      = pos_x > cnt_x;
    stat.pos_eq      = pos_x == cnt_x;
    stat.last_pos    = (pos_x + CMP_W'(1)) == cnt_x;
    stat.full        = count == COUNT_W'(CAPACITY);
    stat.count_zero  = count == '0;
    stat.scan_at_pos = scan == IDX_W'(pos_q);
    stat.scan_at_top = (CMP_W'(scan) + CMP_W'(1)) == cnt_x;
    stat.hit         = hit;
    stat.pend_valid  = pend_valid;
  end

  // Transaction capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= mode_t'(mode);
      pos_q   <= position;
      key     <= normalize_name({name_word2, name_word1, name_word0});
      score_q <= score_in;
    end
  end

  // Record memory: one read and one write port, read data registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[scan];
    end
    if (mv_valid) begin
      mem[mv_dst] <= rd_data;
    end else if (cmd.write_new) begin
      mem[IDX_W'(pos_q)] <= '{name: key, score: score_q};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_load) begin
      unique case (cmd.scan_sel)
        SCAN_TOP:  scan <= IDX_W'(count - COUNT_W'(1));
        SCAN_NEXT: scan <= IDX_W'(pos_x + CMP_W'(1));
        default:   scan <= '0;
      endcase
    end else if (cmd.shift_up) begin
      scan <= scan - IDX_W'(1);
    end else if (cmd.shift_down || cmd.scan_read) begin
      scan <= scan + IDX_W'(1);
    end
    // A record read while shifting is written one place over on the next cycle.
    if (cmd.shift_up) begin
      mv_dst <= scan + IDX_W'(1);
    end else begin
      mv_dst <= scan - IDX_W'(1);
    end
    chk_idx <= scan;
    if (hit) begin
      pend_idx   <= chk_idx;
      pend_score <= rd_data.score;
    end
    if (cmd.scan_load) begin
      best <= '0;
    end else if (chk_valid && (rd_data.score > best)) begin
      best <= rd_data.score;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      mv_valid   <= 1'b0;
      chk_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      mv_valid  <= cmd.shift_up || cmd.shift_down;
      chk_valid <= cmd.scan_read;
      if (cmd.scan_load) begin
        pend_valid <= 1'b0;
      end else if (hit) begin
        pend_valid <= 1'b1;
      end
      if (cmd.count_inc) begin
        count <= count + COUNT_W'(1);
      end else if (cmd.count_dec) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status         <= cmd.emit_status;
      entry_total    <= TOTAL_W'(count);
      max_mark       <= '0;
      found          <= 1'b0;
      match_position <= '0;
      match_score    <= '0;
      last           <= 1'b1;
      unique case (cmd.emit_kind)
        EMIT_INSERTED: entry_total <= TOTAL_W'(count + COUNT_W'(1));
        EMIT_DELETED:  entry_total <= TOTAL_W'(count - COUNT_W'(1));
        EMIT_MAX:      max_mark    <= best[SCORE_W-1 -: MARK_W];
        EMIT_MORE: begin
          found          <= 1'b1;
          match_position <= POS_W'(pend_idx);
          match_score    <= pend_score;
          last           <= 1'b0;
        end
        EMIT_LAST: begin
          found          <= 1'b1;
          match_position <= POS_W'(pend_idx);
          match_score    <= pend_score;
        end
        default: begin
        end
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("record count above capacity");

  a_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(mv_valid && cmd.write_new))
    else $error("new record written while a shift write is pending");

  a_scan_vs_move: assert property (@(posedge clk) disable iff (rst)
    !(chk_valid && mv_valid))
    else $error("scan check and shift move in the same cycle");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (cmd.emit_kind == EMIT_INSERTED)) |=> (count == $past(count) + COUNT_W'(1)))
    else $error("insert did not grow the record count");

endmodule

// ===== rtl/core/irl_controller.sv =====
// ----------------------------------------------------------------------------
// irl_controller
// Sequencer for the indexed record list: decides each transaction, runs the
// shift and scan passes and orders the results.
// ----------------------------------------------------------------------------
module irl_controller
  import irl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.scan_sel    = SCAN_ZERO;
    cmd.emit_kind   = EMIT_PLAIN;
    cmd.emit_status = STATUS_OK;
    busy            = state != ST_IDLE;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        state_next = ST_IDLE;
        unique case (stat.mode)
          MODE_INSERT: begin
            priority if (stat.pos_gt) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = STATUS_RANGE;
            end else if (stat.full) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = STATUS_FULL;
            end else if (stat.pos_eq) begin
              state_next = ST_INS_WRITE;
            end else begin
              cmd.scan_load = 1'b1;
              cmd.scan_sel  = SCAN_TOP;
              state_next    = ST_SHIFT_UP;
            end
          end
          MODE_DELETE: begin
            priority if (stat.pos_gt || stat.pos_eq) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = STATUS_RANGE;
            end else if (stat.last_pos) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = EMIT_DELETED;
              cmd.count_dec = 1'b1;
            end else begin
              cmd.scan_load = 1'b1;
              cmd.scan_sel  = SCAN_NEXT;
              state_next    = ST_SHIFT_DOWN;
            end
          end
          default: begin
            cmd.scan_load = 1'b1;
            cmd.scan_sel  = SCAN_ZERO;
            state_next    = stat.count_zero ? ST_SCAN_END : ST_SCAN;
          end
        endcase
      end

      ST_SHIFT_UP: begin
        cmd.shift_up = 1'b1;
        if (stat.scan_at_pos) begin
          state_next = ST_FLUSH;
        end
      end

      ST_SHIFT_DOWN: begin
        cmd.shift_down = 1'b1;
        if (stat.scan_at_top) begin
          state_next = ST_FLUSH;
        end
      end

      // The last shifted record is written back in this cycle.
      ST_FLUSH: begin
        if (stat.mode == MODE_INSERT) begin
          state_next = ST_INS_WRITE;
        end else begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EMIT_DELETED;
          cmd.count_dec = 1'b1;
          state_next    = ST_IDLE;
        end
      end

      ST_INS_WRITE: begin
        cmd.write_new = 1'b1;
        cmd.count_inc = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_kind = EMIT_INSERTED;
        state_next    = ST_IDLE;
      end

      ST_SCAN, ST_DRAIN: begin
        cmd.scan_read = (state == ST_SCAN);
        // A new match releases the one held before it, which is then not last.
        if (stat.hit && stat.pend_valid) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EMIT_MORE;
        end
        if (state == ST_DRAIN) begin
          state_next = ST_SCAN_END;
        end else if (stat.scan_at_top) begin
          state_next = ST_DRAIN;
        end
      end

      ST_SCAN_END: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
        if (stat.mode == MODE_MAX) begin
          cmd.emit_kind = EMIT_MAX;
        end else if (stat.pend_valid) begin
          cmd.emit_kind = EMIT_LAST;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_idle_no_more: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !(cmd.emit && (cmd.emit_kind == EMIT_MORE)))
    else $error("intermediate match emitted while idle");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!busy && start))
    else $error("transaction loaded while busy");

  a_decide_follows_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_DECIDE))
    else $error("loaded transaction not decided next cycle");

endmodule

// ===== rtl/core/indexed_record_list.sv =====
// ----------------------------------------------------------------------------
// indexed_record_list
// Ordered table of named records with fixed-point scores: insert and delete
// at a position, maximum score and find by name.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low;
//   mode, position, the three name words and score_in are sampled then.
//   Each result appears for one cycle with done high. The receiver cannot
//   stall, so results are simply produced one after another.
//   Insert and delete shift the table one record per cycle through the
//   read port and the write port of the record memory. With n records, an
//   insert at p below n keeps busy high through decide, the moves of records
//   p to n-1, flush and write, and one at p equal to n through decide and
//   write; a rejected insert or delete only decides. A delete at p decides,
//   moves records p+1 to n-1 and flushes, or only decides when p is the last
//   record. Max and find scan all n records, one memory read per cycle,
//   through decide, scan, drain and scan end, or decide and scan end on an
//   empty table; find emits each match as soon as the next match or the end
//   of the scan shows whether it is the last. Every result is registered, so
//   done follows the cycle that issues it. Reset empties the table at once;
//   no clearing pass is needed: only records below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_record_list
  import irl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode,
  input  logic [POS_W-1:0]    position,
  input  logic [WORD_W-1:0]   name_word0,
  input  logic [WORD_W-1:0]   name_word1,
  input  logic [WORD_W-1:0]   name_word2,
  input  logic [SCORE_W-1:0]  score_in,
  output logic                done,
  output logic [1:0]          status,
  output logic [TOTAL_W-1:0]  entry_total,
  output logic [MARK_W-1:0]   max_mark,
  output logic                found,
  output logic [POS_W-1:0]    match_position,
  output logic [SCORE_W-1:0]  match_score,
  output logic                last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  irl_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  irl_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .mode           (mode),
    .position       (position),
    .name_word0     (name_word0),
    .name_word1     (name_word1),
    .name_word2     (name_word2),
    .score_in       (score_in),
    .done           (done),
    .status         (status),
    .entry_total    (entry_total),
    .max_mark       (max_mark),
    .found          (found),
    .match_position (match_position),
    .match_score    (match_score),
    .last           (last)
  );

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the indexed record list
// Drives insert, delete, max and find transactions into the block and checks
// every result against a behavioural copy of the record table. A directed
// opening covers the empty and full table, rejected positions and name
// clean-up; a random part swings the table between empty and full.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import irl_pkg::*;

  localparam int RANDOM_ITEMS   = 276;
  localparam int SETTLE_CYCLES  = 2 * CAPACITY + 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int POOL_SIZE      = 6;
  localparam int REPORT_CAP     = 40;

  localparam logic [NAME_W-1:0] NAME_ALPHA      = {64'h0, 64'h0, 64'h0000_0061_6870_6c61};
  localparam logic [NAME_W-1:0] NAME_BETA       = {64'h0, 64'h0, 64'h0000_0000_6174_6562};
  localparam logic [NAME_W-1:0] NAME_BETA_DIRTY = {64'h1234_5678_9ABC_DEF0,
                                                   64'hFFFF_FFFF_FFFF_FFFF,
                                                   64'hA5C3_1100_6174_6562};
  localparam logic [NAME_W-1:0] NAME_LONG       = {64'h0000_0000_5453_5251,
                                                   64'h504F_4E4D_4C4B_4A49,
                                                   64'h4847_4645_4443_4241};
  localparam logic [NAME_W-1:0] NAME_LONG_DIRTY = {64'hDEAD_BEEF_5453_5251,
                                                   64'h504F_4E4D_4C4B_4A49,
                                                   64'h4847_4645_4443_4241};

  typedef struct {
    status_t              status;
    logic [TOTAL_W-1:0]   total;
    logic [MARK_W-1:0]    mark;
    logic                 found;
    logic [POS_W-1:0]     where;
    logic [SCORE_W-1:0]   score;
    logic                 last;
  } list_result_t;

  // Behavioural copy of the record table and the results it still owes.
  class record_list_model;
    logic [NAME_W-1:0]  names  [CAPACITY];
    logic [SCORE_W-1:0] scores [CAPACITY];
    int                 held;
    list_result_t       awaited [$];
    int                 errors;
    int                 op_count [4];
    int                 checked;
    int                 hits;
    int                 rejects_range;
    int                 rejects_full;
    int                 full_visits;
    int                 empty_max;

    function new();
      held          = 0;
      errors        = 0;
      checked       = 0;
      hits          = 0;
      rejects_range = 0;
      rejects_full  = 0;
      full_visits   = 0;
      empty_max     = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    // Keeps the bytes before the first zero byte within the name limit.
    function logic [NAME_W-1:0] canonical_name(logic [NAME_W-1:0] raw);
      int                len;
      logic [NAME_W-1:0] res;
      len = NAME_BYTES;
      for (int i = NAME_BYTES - 1; i >= 0; i--) begin
        if (raw[i*8 +: 8] == 8'h00) len = i;
      end
      res = '0;
      for (int i = 0; i < len; i++) res[i*8 +: 8] = raw[i*8 +: 8];
      return res;
    endfunction

    function void queue_result(status_t st, logic [MARK_W-1:0] mark, logic hit, int where,
                               logic [SCORE_W-1:0] sc, logic fin);
      list_result_t r;
      r.status = st;
      r.total  = TOTAL_W'(held);
      r.mark   = mark;
      r.found  = hit;
      r.where  = POS_W'(where);
      r.score  = sc;
      r.last   = fin;
      awaited.push_back(r);
    endfunction

    function void apply_command(mode_t op, int at, logic [NAME_W-1:0] raw,
                                logic [SCORE_W-1:0] sc);
      logic [NAME_W-1:0]  key;
      logic [SCORE_W-1:0] best;
      int                 match_list [$];
      key = canonical_name(raw);
      op_count[op]++;
      case (op)
        MODE_INSERT: begin
          if (at > held) begin
            rejects_range++;
            queue_result(STATUS_RANGE, '0, 1'b0, 0, '0, 1'b1);
          end else if (held >= CAPACITY) begin
            rejects_full++;
            queue_result(STATUS_FULL, '0, 1'b0, 0, '0, 1'b1);
          end else begin
            for (int i = held; i > at; i--) begin
              names[i]  = names[i-1];
              scores[i] = scores[i-1];
            end
            names[at]  = key;
            scores[at] = sc;
            held++;
            if (held == CAPACITY) full_visits++;
            queue_result(STATUS_OK, '0, 1'b0, 0, '0, 1'b1);
          end
        end
        MODE_DELETE: begin
          if (at >= held) begin
            rejects_range++;
            queue_result(STATUS_RANGE, '0, 1'b0, 0, '0, 1'b1);
          end else begin
            for (int i = at; i + 1 < held; i++) begin
              names[i]  = names[i+1];
              scores[i] = scores[i+1];
            end
            held--;
            queue_result(STATUS_OK, '0, 1'b0, 0, '0, 1'b1);
          end
        end
        MODE_MAX: begin
          best = '0;
          for (int i = 0; i < held; i++) begin
            if (scores[i] > best) best = scores[i];
          end
          if (held == 0) empty_max++;
          queue_result(STATUS_OK, best[SCORE_W-1 -: MARK_W], 1'b0, 0, '0, 1'b1);
        end
        default: begin
          for (int i = 0; i < held; i++) begin
            if (names[i] == key) match_list.push_back(i);
          end
          if (match_list.size() == 0) begin
            queue_result(STATUS_OK, '0, 1'b0, 0, '0, 1'b1);
          end else begin
            hits += match_list.size();
            foreach (match_list[k]) begin
              queue_result(STATUS_OK, '0, 1'b1, match_list[k], scores[match_list[k]],
                           k == match_list.size() - 1);
            end
          end
        end
      endcase
    endfunction

    function void compare(string field, logic [SCORE_W-1:0] want, logic [SCORE_W-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_CAP) begin
          $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
      end
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP) begin
          $display("%0t ns: result with nothing outstanding, expected none, actual status %0d",
                   $time, got.status);
        end
        return;
      end
      want = awaited.pop_front();
      compare("status", SCORE_W'(want.status), SCORE_W'(got.status));
      compare("entry_total", SCORE_W'(want.total), SCORE_W'(got.total));
      compare("max_mark", SCORE_W'(want.mark), SCORE_W'(got.mark));
      compare("found", SCORE_W'(want.found), SCORE_W'(got.found));
      compare("match_position", SCORE_W'(want.where), SCORE_W'(got.where));
      compare("match_score", want.score, got.score);
      compare("last", SCORE_W'(want.last), SCORE_W'(got.last));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [1:0]          mode;
  logic [POS_W-1:0]    position;
  logic [WORD_W-1:0]   name_word0;
  logic [WORD_W-1:0]   name_word1;
  logic [WORD_W-1:0]   name_word2;
  logic [SCORE_W-1:0]  score_in;
  logic                done;
  logic [1:0]          status;
  logic [TOTAL_W-1:0]  entry_total;
  logic [MARK_W-1:0]   max_mark;
  logic                found;
  logic [POS_W-1:0]    match_position;
  logic [SCORE_W-1:0]  match_score;
  logic                last;

  record_list_model    shadow_list = new();
  logic [NAME_W-1:0]   name_pool [POOL_SIZE];
  int                  name_len  [POOL_SIZE];
  int                  idle_cycles = 0;

  indexed_record_list u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    list_result_t got;
    if (!rst && done) begin
      got.status = status_t'(status);
      got.total  = entry_total;
      got.mark   = max_mark;
      got.found  = found;
      got.where  = match_position;
      got.score  = match_score;
      got.last   = last;
      shadow_list.check_result(got);
    end
  end

  // Counts cycles in which neither a command nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic logic [NAME_W-1:0] random_string(int len);
    logic [NAME_W-1:0] res;
    res = '0;
    for (int i = 0; i < len; i++) res[i*8 +: 8] = 8'($urandom_range(1, 255));
    return res;
  endfunction

  // Mostly names from the pool, half of them with rubbish after the end of
  // the string, plus names of random length and wholly random words.
  function automatic logic [NAME_W-1:0] pick_name();
    int                k;
    int                len;
    logic [NAME_W-1:0] res;
    k = $urandom_range(0, 9);
    if (k >= POOL_SIZE + 2) return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (k >= POOL_SIZE) return random_string($urandom_range(0, NAME_SLOTS));
    res = name_pool[k];
    len = name_len[k];
    if ($urandom_range(0, 1) == 1) begin
      for (int i = (len < NAME_BYTES) ? len + 1 : NAME_BYTES; i < NAME_SLOTS; i++) begin
        res[i*8 +: 8] = 8'($urandom);
      end
    end
    return res;
  endfunction

  task automatic send_command(mode_t op, int at, logic [NAME_W-1:0] raw,
                              logic [SCORE_W-1:0] sc);
    @(negedge clk);
    start      <= 1'b1;
    mode       <= op;
    position   <= POS_W'(at);
    name_word0 <= raw[63:0];
    name_word1 <= raw[127:64];
    name_word2 <= raw[191:128];
    score_in   <= sc;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    shadow_list.apply_command(op, at, raw, sc);
  endtask

  task automatic hold_off(int cycles);
    @(negedge clk) start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    @(negedge clk) start <= 1'b0;
    while (shadow_list.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    send_command(MODE_MAX, 0, NAME_ALPHA, '0);
    send_command(MODE_FIND, 0, NAME_ALPHA, '0);
    send_command(MODE_DELETE, 0, NAME_ALPHA, '0);
    send_command(MODE_INSERT, 1, NAME_ALPHA, 16'h0100);
    send_command(MODE_INSERT, 0, NAME_ALPHA, 16'hFFFF);
    send_command(MODE_INSERT, 1, NAME_BETA_DIRTY, 16'h0000);
    send_command(MODE_INSERT, 0, NAME_LONG_DIRTY, 16'h1280);
    // Both lookups must match the stored names despite the trailing bytes.
    send_command(MODE_FIND, 0, NAME_BETA, '0);
    send_command(MODE_FIND, 0, NAME_LONG, '0);
    send_command(MODE_INSERT, 2, NAME_ALPHA, 16'h0101);
    send_command(MODE_FIND, 63, NAME_ALPHA, '0);
    send_command(MODE_FIND, 0, '1, '1);
    send_command(MODE_MAX, 0, '0, '0);
    send_command(MODE_DELETE, 63, '0, '0);
    send_command(MODE_DELETE, 3, '0, '0);
    send_command(MODE_DELETE, 0, '0, '0);
    while (shadow_list.held < CAPACITY) begin
      send_command(MODE_INSERT, $urandom_range(0, shadow_list.held), NAME_ALPHA,
                   SCORE_W'($urandom));
    end
    send_command(MODE_INSERT, 0, NAME_BETA, 16'h0001);
    send_command(MODE_INSERT, CAPACITY + 1, NAME_BETA, 16'h0001);
    send_command(MODE_FIND, 0, NAME_ALPHA, '0);
    send_command(MODE_MAX, 0, '0, '0);
  endtask

  task automatic send_random(bit filling);
    int                 roll;
    int                 at;
    int                 held;
    mode_t              op;
    logic [SCORE_W-1:0] sc;
    held = shadow_list.held;
    roll = $urandom_range(0, 99);
    if (filling) begin
      op = (roll < 55) ? MODE_INSERT : (roll < 70) ? MODE_DELETE :
           (roll < 80) ? MODE_MAX : MODE_FIND;
    end else begin
      op = (roll < 15) ? MODE_INSERT : (roll < 60) ? MODE_DELETE :
           (roll < 70) ? MODE_MAX : MODE_FIND;
    end
    if ($urandom_range(0, 6) == 0) begin
      at = $urandom_range(0, 63);
    end else if (op == MODE_INSERT) begin
      at = $urandom_range(0, held);
    end else if (op == MODE_DELETE && held > 0) begin
      at = $urandom_range(0, held - 1);
    end else begin
      at = $urandom_range(0, 63);
    end
    case ($urandom_range(0, 9))
      0:       sc = '0;
      1:       sc = '1;
      default: sc = SCORE_W'($urandom);
    endcase
    send_command(op, at, pick_name(), sc);
  endtask

  // Bursts of back-to-back transactions with gaps between them; the bias
  // between inserts and deletes flips so that the table fills and empties.
  task automatic run_random(int total);
    int burst;
    bit filling;
    burst   = 0;
    filling = 1'b1;
    for (int n = 0; n < total; n++) begin
      if (n % 45 == 44) filling = !filling;
      if (n % 100 == 99) begin
        wait_for_drain();
      end else if (burst <= 0) begin
        burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
        if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
      end
      burst--;
      send_random(filling);
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    mode       = '0;
    position   = '0;
    name_word0 = '0;
    name_word1 = '0;
    name_word2 = '0;
    score_in   = '0;
    // The last pool name extends the one before it by a single byte.
    name_len = '{0, 1, NAME_BYTES, 4, 7, 8};
    for (int i = 0; i < POOL_SIZE - 1; i++) name_pool[i] = random_string(name_len[i]);
    name_pool[POOL_SIZE-1] = name_pool[POOL_SIZE-2];
    name_pool[POOL_SIZE-1][7*8 +: 8] = 8'($urandom_range(1, 255));
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    run_directed();
    wait_for_drain();
    run_random(RANDOM_ITEMS);
    wait_for_drain();
    $display("Covered %0d transactions (%0d insert, %0d delete, %0d max, %0d find), %0d results.",
             shadow_list.op_count[MODE_INSERT] + shadow_list.op_count[MODE_DELETE] +
             shadow_list.op_count[MODE_MAX] + shadow_list.op_count[MODE_FIND],
             shadow_list.op_count[MODE_INSERT], shadow_list.op_count[MODE_DELETE],
             shadow_list.op_count[MODE_MAX], shadow_list.op_count[MODE_FIND],
             shadow_list.checked);
    $display("Rejections: %0d position, %0d full; %0d find hits; table filled %0d times.",
             shadow_list.rejects_range, shadow_list.rejects_full, shadow_list.hits,
             shadow_list.full_visits);
    if (shadow_list.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
